// ===== rtl/core/lpr_pkg.sv =====
// Shared types for the longest-prefix route lookup core.
// Holds the write command, the search token and the result beat layout.
// No dependencies.
`default_nettype none

package lpr_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 8;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned COUNT_W = 9;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed
    {
        logic               en;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  prefix;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [PORT_W-1:0]  port;
    } wr_t;

    typedef struct packed
    {
        logic               valid;
        logic [ADDR_W-1:0]  dest;
        logic               hit;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [PORT_W-1:0]  port;
        logic [INDEX_W-1:0] index;
    } token_t;

    typedef struct packed
    {
        logic               found;
        logic [ADDR_W-1:0]  gateway;
        logic [PORT_W-1:0]  port;
        logic [INDEX_W-1:0] index;
    } result_t;

    function automatic result_t to_result(input token_t tok);
        result_t res;
        res.found   = tok.hit;
        res.gateway = tok.hit ? tok.gateway : '0;
        res.port    = tok.hit ? tok.port : '0;
        res.index   = tok.hit ? tok.index : '0;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpr_if.sv =====
// Request and response channel interfaces of the route lookup core.
// Depends on lpr_pkg for field widths.
`default_nettype none

interface lpr_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [lpr_pkg::INDEX_W-1:0]   entry_index;
    logic [lpr_pkg::ADDR_W-1:0]    entry_prefix;
    logic [lpr_pkg::ADDR_W-1:0]    entry_mask;
    logic [lpr_pkg::ADDR_W-1:0]    entry_next_hop;
    logic [lpr_pkg::PORT_W-1:0]    entry_port;
    logic [lpr_pkg::ADDR_W-1:0]    dest_address;

    modport source
    (
        output valid, operation, entry_index, entry_prefix, entry_mask,
               entry_next_hop, entry_port, dest_address,
        input  ready
    );

    modport sink
    (
        input  valid, operation, entry_index, entry_prefix, entry_mask,
               entry_next_hop, entry_port, dest_address,
        output ready
    );
endinterface

interface lpr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [lpr_pkg::ADDR_W-1:0]    route_next_hop;
    logic [lpr_pkg::PORT_W-1:0]    route_port;
    logic [lpr_pkg::INDEX_W-1:0]   route_index;

    modport source
    (
        output valid, found, route_next_hop, route_port, route_index,
        input  ready
    );

    modport sink
    (
        input  valid, found, route_next_hop, route_port, route_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/lpr_cell.sv =====
// One table slot of the lookup chain: stores an entry and compares the
// passing search token against it. Depends on lpr_pkg.
`default_nettype none

module lpr_cell #(
    parameter int INDEX = 0
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire lpr_pkg::wr_t             wr,
    input  wire [lpr_pkg::COUNT_W-1:0]    count,
    input  wire lpr_pkg::token_t          tok_in,
    output lpr_pkg::token_t               tok_out
);

    logic [lpr_pkg::ADDR_W-1:0] prefix_reg;
    logic [lpr_pkg::ADDR_W-1:0] mask_reg;
    logic [lpr_pkg::ADDR_W-1:0] gateway_reg;
    logic [lpr_pkg::PORT_W-1:0] port_reg;

    logic             sel;
    logic             active;
    logic             take;
    lpr_pkg::token_t  tok_next;
    lpr_pkg::token_t  tok_reg;

    assign sel    = wr.en && (32'(wr.index) == 32'(INDEX));
    assign active = 32'(count) > 32'(INDEX);
    assign take   = active && ((tok_in.dest & mask_reg) == prefix_reg)
                    && (!tok_in.hit || (mask_reg > tok_in.mask));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.hit     = 1'b1;
            tok_next.mask    = mask_reg;
            tok_next.gateway = gateway_reg;
            tok_next.port    = port_reg;
            tok_next.index   = lpr_pkg::INDEX_W'(INDEX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            prefix_reg  <= wr.prefix;
            mask_reg    <= wr.mask;
            gateway_reg <= wr.gateway;
            port_reg    <= wr.port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/core/longest_prefix_route_lookup_core.sv =====
// A lookup beat's search token visits one slot cell per cycle; the last cell's
// token is registered in the output register as the result beat, or held in a
// pending register while the output stalls. No beat is taken during a lookup.
// A new beat is taken while a finished result waits in the output register.
// Reset clears the control state and count_reg; table slots keep no
// reset value and must be written before they are searched.
`default_nettype none

module longest_prefix_route_lookup_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_wr_en,
    input  wire [lpr_pkg::COUNT_W-1:0] cfg_wr_data,
    lpr_req_if.sink                    req,
    lpr_rsp_if.source                  rsp
);

    logic [lpr_pkg::COUNT_W-1:0] count_reg;
    logic                        busy_reg;
    logic                        pend_valid_reg;
    lpr_pkg::result_t            pend_reg;
    logic                        out_valid_reg;
    lpr_pkg::result_t            out_reg;

    logic              accept;
    logic              lookup;
    logic              load_out;
    lpr_pkg::wr_t      wr;
    lpr_pkg::token_t   chain [TABLE_DEPTH+1];
    lpr_pkg::token_t   fin;

    assign req.ready = !busy_reg && !pend_valid_reg;
    assign accept    = req.valid && req.ready;
    assign lookup    = accept && (req.operation == lpr_pkg::OP_LOOKUP);

    assign wr.en      = accept && (req.operation == lpr_pkg::OP_WRITE);
    assign wr.index   = req.entry_index;
    assign wr.prefix  = req.entry_prefix;
    assign wr.mask    = req.entry_mask;
    assign wr.gateway = req.entry_next_hop;
    assign wr.port    = req.entry_port;

    always_comb
    begin
        chain[0]          = '0;
        chain[0].valid    = lookup;
        chain[0].dest     = req.dest_address;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        lpr_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .count   (count_reg),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign fin      = chain[TABLE_DEPTH];
    assign load_out = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (lookup)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin.valid)
            begin
                busy_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg  <= pend_valid_reg || fin.valid;
                pend_valid_reg <= 1'b0;
            end
            else if (fin.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= pend_valid_reg ? pend_reg : lpr_pkg::to_result(fin);
        end
        else if (fin.valid)
        begin
            pend_reg <= lpr_pkg::to_result(fin);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.found          = out_reg.found;
    assign rsp.route_next_hop = out_reg.gateway;
    assign rsp.route_port     = out_reg.port;
    assign rsp.route_index    = out_reg.index;

endmodule

`default_nettype wire

// ===== rtl/core/lpr_checker.sv =====
// Port-level checks for the route lookup core, bound to the top level.
// Depends on lpr_pkg and on the top level's channel ports.
`default_nettype none

module lpr_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          req_valid,
    input wire                          req_ready,
    input wire                          req_operation,
    input wire                          rsp_valid,
    input wire                          rsp_ready,
    input wire                          rsp_found,
    input wire [lpr_pkg::ADDR_W-1:0]    rsp_route_next_hop,
    input wire [lpr_pkg::PORT_W-1:0]    rsp_route_port,
    input wire [lpr_pkg::INDEX_W-1:0]   rsp_route_index
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation == lpr_pkg::OP_LOOKUP)
        |=> !req_ready)
        else $error("request taken while a lookup is in flight");

    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid && (req_operation == lpr_pkg::OP_LOOKUP)))
        else $error("request ready dropped without a lookup beat");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> (rsp_route_next_hop == '0)
        && (rsp_route_port == '0) && (rsp_route_index == '0))
        else $error("miss result carries nonzero route fields");

endmodule

bind longest_prefix_route_lookup_core lpr_checker u_lpr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_operation      (req.operation),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_found          (rsp.found),
    .rsp_route_next_hop (rsp.route_next_hop),
    .rsp_route_port     (rsp.route_port),
    .rsp_route_index    (rsp.route_index)
);

`default_nettype wire

// ===== bench/lpr_route_checker.sv =====
`timescale 1ns / 1ps
// Route lookup checker: mirrors the routing table and the search count, predicts
// each lookup beat and compares result beats in order. Depends on lpr_pkg, lpr_if.
module lpr_route_checker
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_wr_en,
    input  wire [lpr_pkg::COUNT_W-1:0] cfg_wr_data,
    lpr_req_if                         req,
    lpr_rsp_if                         rsp,
    output int                         outstanding,
    output int                         failures
);

    localparam int DEPTH = 256;

    logic [lpr_pkg::ADDR_W-1:0]  tbl_prefix  [DEPTH];
    logic [lpr_pkg::ADDR_W-1:0]  tbl_mask    [DEPTH];
    logic [lpr_pkg::ADDR_W-1:0]  tbl_gateway [DEPTH];
    logic [lpr_pkg::PORT_W-1:0]  tbl_port    [DEPTH];
    logic [lpr_pkg::COUNT_W-1:0] search_count;
    lpr_pkg::result_t            expected_routes [$];

    function automatic lpr_pkg::result_t predict_route(input logic [lpr_pkg::ADDR_W-1:0] dest);
        lpr_pkg::result_t           best;
        logic [lpr_pkg::ADDR_W-1:0] best_mask;
        int                         limit;
        best      = '0;
        best_mask = '0;
        limit     = (search_count > DEPTH) ? DEPTH : int'(search_count);
        for (int i = 0; i < limit; i++)
        begin
            if ((dest & tbl_mask[i]) == tbl_prefix[i]
                && (!best.found || tbl_mask[i] > best_mask))
            begin
                best.found   = 1'b1;
                best.gateway = tbl_gateway[i];
                best.port    = tbl_port[i];
                best.index   = i[lpr_pkg::INDEX_W-1:0];
                best_mask    = tbl_mask[i];
            end
        end
        return best;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lpr_pkg::result_t want;
        if (!rst_n)
        begin
            search_count = '0;
            expected_routes.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                search_count = cfg_wr_data;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_routes.size() == 0)
                begin
                    $error("result beat with no lookup pending: found %0d gateway %h",
                           rsp.found, rsp.route_next_hop);
                    failures++;
                end
                else
                begin
                    want = expected_routes.pop_front();
                    check_field("found", 32'(want.found), 32'(rsp.found));
                    check_field("route_next_hop", want.gateway, rsp.route_next_hop);
                    check_field("route_port", 32'(want.port), 32'(rsp.route_port));
                    check_field("route_index", 32'(want.index), 32'(rsp.route_index));
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.operation == lpr_pkg::OP_LOOKUP)
                    expected_routes.push_back(predict_route(req.dest_address));
                else
                begin
                    tbl_prefix[req.entry_index]  = req.entry_prefix;
                    tbl_mask[req.entry_index]    = req.entry_mask;
                    tbl_gateway[req.entry_index] = req.entry_next_hop;
                    tbl_port[req.entry_index]    = req.entry_port;
                end
            end
            outstanding <= expected_routes.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Bench top for the route lookup core: clock, reset, table writes, lookups and
// search-count phases under random stalls. Depends on lpr_pkg, lpr_if, lpr_route_checker.
module tb_top;

    localparam int DEPTH            = 256;
    localparam int ITEM_TARGET      = 1750;
    localparam int SETTLE_CYCLES    = DEPTH + 40;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int LIMIT_CYCLES     = 3000000;

    typedef struct packed
    {
        lpr_pkg::op_t                op;
        logic [lpr_pkg::INDEX_W-1:0] index;
        logic [lpr_pkg::ADDR_W-1:0]  prefix;
        logic [lpr_pkg::ADDR_W-1:0]  mask;
        logic [lpr_pkg::ADDR_W-1:0]  gateway;
        logic [lpr_pkg::PORT_W-1:0]  port;
        logic [lpr_pkg::ADDR_W-1:0]  dest;
    } req_beat_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [lpr_pkg::COUNT_W-1:0] cfg_wr_data;
    int                          outstanding;
    int                          failures;

    lpr_req_if req_ch();
    lpr_rsp_if rsp_ch();

    logic [lpr_pkg::ADDR_W-1:0]  tb_prefix [DEPTH];
    logic [lpr_pkg::ADDR_W-1:0]  tb_mask   [DEPTH];
    bit                          written   [DEPTH];
    int                          written_prefix = 0;
    int                          count_now = 0;
    int                          items_sent = 0;
    int                          hold_requests = 0;

    longest_prefix_route_lookup_core #(.TABLE_DEPTH(DEPTH)) dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    lpr_route_checker route_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 98)
            return $urandom_range(5, 30);
        return $urandom_range(31, 120);
    endfunction

    function automatic int search_limit();
        return (count_now > DEPTH) ? DEPTH : count_now;
    endfunction

    function automatic logic [lpr_pkg::ADDR_W-1:0] rand_mask();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            len = $urandom_range(0, 32);
            return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
        end
        if (r < 75)
            return $urandom;
        if (r < 85)
            return 32'h0;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic req_beat_t make_entry(input int slot,
                                             input logic [lpr_pkg::ADDR_W-1:0] prefix,
                                             input logic [lpr_pkg::ADDR_W-1:0] mask,
                                             input logic [lpr_pkg::ADDR_W-1:0] gateway,
                                             input logic [lpr_pkg::PORT_W-1:0] port);
        req_beat_t b;
        b.op      = lpr_pkg::OP_WRITE;
        b.index   = slot[lpr_pkg::INDEX_W-1:0];
        b.prefix  = prefix;
        b.mask    = mask;
        b.gateway = gateway;
        b.port    = port;
        b.dest    = $urandom;
        return b;
    endfunction

    function automatic req_beat_t make_write(input int slot);
        logic [lpr_pkg::ADDR_W-1:0] mask;
        logic [lpr_pkg::ADDR_W-1:0] prefix;
        logic [31:0]                rnd;
        int                         src;
        if ($urandom_range(0, 9) == 0 && written_prefix > 0)
        begin
            src    = $urandom_range(0, written_prefix - 1);
            mask   = tb_mask[src];
            prefix = tb_prefix[src];
        end
        else
        begin
            mask   = rand_mask();
            prefix = ($urandom_range(0, 9) < 7) ? ($urandom & mask) : $urandom;
        end
        rnd = $urandom;
        return make_entry(slot, prefix, mask, $urandom, rnd[lpr_pkg::PORT_W-1:0]);
    endfunction

    function automatic int pick_write_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && written_prefix < DEPTH)
            return written_prefix;
        if (r < 60 && search_limit() > 0)
            return $urandom_range(0, search_limit() - 1);
        return $urandom_range(0, DEPTH - 1);
    endfunction

    function automatic req_beat_t make_probe(input logic [lpr_pkg::ADDR_W-1:0] dest);
        req_beat_t   b;
        logic [31:0] rnd;
        b.op      = lpr_pkg::OP_LOOKUP;
        rnd       = $urandom;
        b.index   = rnd[lpr_pkg::INDEX_W-1:0];
        b.prefix  = $urandom;
        b.mask    = $urandom;
        b.gateway = $urandom;
        rnd       = $urandom;
        b.port    = rnd[lpr_pkg::PORT_W-1:0];
        b.dest    = dest;
        return b;
    endfunction

    function automatic req_beat_t make_lookup();
        int s;
        if (search_limit() > 0 && $urandom_range(0, 99) < 65)
        begin
            s = $urandom_range(0, search_limit() - 1);
            return make_probe((tb_prefix[s] & tb_mask[s]) | ($urandom & ~tb_mask[s]));
        end
        return make_probe($urandom);
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (written_prefix == DEPTH)
        begin
            if (r == 1)
                return DEPTH;
            if (r == 2)
                return 511;
            if (r == 3)
                return $urandom_range(DEPTH + 1, 511);
        end
        if (r < 5)
            return written_prefix;
        return $urandom_range(1, written_prefix);
    endfunction

    task automatic send_beat(input req_beat_t b, input int gap);
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= b.op;
        req_ch.entry_index    <= b.index;
        req_ch.entry_prefix   <= b.prefix;
        req_ch.entry_mask     <= b.mask;
        req_ch.entry_next_hop <= b.gateway;
        req_ch.entry_port     <= b.port;
        req_ch.dest_address   <= b.dest;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        if (b.op == lpr_pkg::OP_WRITE)
        begin
            tb_prefix[b.index] = b.prefix;
            tb_mask[b.index]   = b.mask;
            written[b.index]   = 1'b1;
            while (written_prefix < DEPTH && written[written_prefix])
                written_prefix++;
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic lookup(input logic [lpr_pkg::ADDR_W-1:0] dest);
        send_beat(make_probe(dest), pick_gap());
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_count(input int value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[lpr_pkg::COUNT_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        count_now = value;
    endtask

    task automatic run_directed();
        set_count(0);
        lookup(32'h0A00_0001);
        send_beat(make_entry(0, 32'h0A00_0001, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00), pick_gap());
        send_beat(make_entry(1, 32'h0A00_0000, 32'hFF00_0000, 32'h1111_1111, 8'h01), pick_gap());
        send_beat(make_entry(2, 32'h0A01_0000, 32'hFFFF_0000, 32'h2222_2222, 8'h02), pick_gap());
        send_beat(make_entry(3, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h3333_3333, 8'h03), pick_gap());
        send_beat(make_entry(4, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h4444_4444, 8'h04), pick_gap());
        send_beat(make_entry(5, 32'h0012_0034, 32'h00FF_00FF, 32'h5555_5555, 8'h55), pick_gap());
        send_beat(make_entry(6, 32'hFFFF_FFFF, 32'h0000_0000, 32'h6666_6666, 8'h66), pick_gap());
        send_beat(make_entry(7, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF), pick_gap());
        send_beat(make_entry(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF),
                  pick_gap());
        set_count(7);
        lookup(32'h0A00_0001);
        lookup(32'h0A01_0203);
        lookup(32'h0A7F_0000);
        lookup(32'hC0A8_0105);
        lookup(32'hFF12_AB34);
        lookup(32'h0102_0304);
        lookup(32'hFFFF_FFFF);
        set_count(8);
        lookup(32'h0102_0304);
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
    endtask

    task automatic run_pressure();
        hold_requests++;
        repeat (12) send_beat(make_lookup(), 0);
        wait_drained();
    endtask

    task automatic run_random();
        int        phase;
        int        n;
        req_beat_t b;
        phase = 0;
        while (items_sent < ITEM_TARGET - 60)
        begin
            set_count(pick_count());
            n = $urandom_range(30, 120);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 45)
                    b = make_lookup();
                else
                    b = make_write(pick_write_slot());
                send_beat(b, pick_gap());
            end
            phase++;
            if (phase == 4)
                run_pressure();
        end
    endtask

    task automatic run_final();
        while (written_prefix < DEPTH)
            send_beat(make_write(written_prefix), pick_gap());
        set_count(DEPTH);
        repeat (15) send_beat(make_lookup(), pick_gap());
        set_count(511);
        repeat (15) send_beat(make_lookup(), pick_gap());
    endtask

    initial
    begin : stimulus
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.operation      <= lpr_pkg::OP_WRITE;
        req_ch.entry_index    <= '0;
        req_ch.entry_prefix   <= '0;
        req_ch.entry_mask     <= '0;
        req_ch.entry_next_hop <= '0;
        req_ch.entry_port     <= '0;
        req_ch.dest_address   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        run_final();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin : receiver
        int gap;
        int holds_done;
        holds_done = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                begin
                    rsp_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 24)) @(posedge clk);
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lpr_pkg.sv
rtl/core/lpr_if.sv
rtl/core/lpr_cell.sv
rtl/core/longest_prefix_route_lookup_core.sv
rtl/core/lpr_checker.sv
bench/lpr_route_checker.sv
bench/tb_top.sv
